>>> rtl/stack_with_pop_maximum_unit_defines.svh
// Assertion macros for the stack with pop-maximum unit.
`ifndef STACK_WITH_POP_MAXIMUM_UNIT_DEFINES_SVH
`define STACK_WITH_POP_MAXIMUM_UNIT_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define SPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define SPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/spm_pkg.sv
// Shared types and constants of the stack with pop-maximum unit.
package spm_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    K_PUSH   = 2'd0,
    K_POP    = 2'd1,
    K_TOP    = 2'd2,
    K_POPMAX = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_SCAN,
    S_SHIFT
  } state_t;

  // Memory access for one cycle.
  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
  } ram_req_t;

  // Finished result, one cycle wide.
  typedef struct packed {
    logic                  valid;
    logic [DATA_WIDTH-1:0] value;
    status_t               status;
    logic [CNT_W-1:0]      count;
  } res_t;

endpackage

>>> rtl/spm_ram.sv
// Element store: one write port, one read port with registered read data.
module spm_ram (
  input  logic                           clk,
  input  spm_pkg::ram_req_t              req,
  output logic [spm_pkg::DATA_WIDTH-1:0] rdata
);

  logic [spm_pkg::DATA_WIDTH-1:0] mem [spm_pkg::DEPTH];

  // Write entry
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read entry, data in the next cycle
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

>>> rtl/spm_ctrl.sv
// Sequencer: push, pop, top, and the scan and shift of pop maximum.
module spm_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [1:0]                     in_kind,
  input  logic [spm_pkg::DATA_WIDTH-1:0] in_push_value,
  input  logic [spm_pkg::DATA_WIDTH-1:0] rdata,
  output logic                           busy,
  output spm_pkg::ram_req_t              req,
  output spm_pkg::res_t                  res
);

  spm_pkg::state_t                state_r, state_nxt;
  logic [spm_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [spm_pkg::ADDR_W-1:0]     idx_r, idx_nxt;
  logic [spm_pkg::ADDR_W-1:0]     best_idx_r, best_idx_nxt;
  logic [spm_pkg::DATA_WIDTH-1:0] best_val_r, best_val_nxt;
  logic                           first_r, first_nxt;
  spm_pkg::kind_t                 kind_r, kind_nxt;

  spm_pkg::kind_t                 kind_in;
  logic                           accept;
  logic                           empty;
  logic                           full;
  logic [spm_pkg::ADDR_W-1:0]     top_idx;
  logic                           cand_better;
  logic [spm_pkg::ADDR_W-1:0]     scan_best_idx;
  logic [spm_pkg::DATA_WIDTH-1:0] scan_best_val;

  // Decode command and scan compare
  always_comb begin
    kind_in       = spm_pkg::kind_t'(in_kind);
    busy          = (state_r != spm_pkg::S_IDLE);
    accept        = start && !busy;
    empty         = (count_r == '0);
    full          = (count_r == spm_pkg::CNT_W'(spm_pkg::DEPTH));
    top_idx       = spm_pkg::ADDR_W'(count_r - spm_pkg::CNT_W'(1));
    cand_better   = first_r || ($signed(rdata) > $signed(best_val_r));
    scan_best_idx = cand_better ? idx_r : best_idx_r;
    scan_best_val = cand_better ? rdata : best_val_r;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spm_pkg::S_IDLE: begin
        if (accept) begin
          unique case (kind_in)
            spm_pkg::K_PUSH:   state_nxt = spm_pkg::S_IDLE;
            spm_pkg::K_POP,
            spm_pkg::K_TOP:    state_nxt = empty ? spm_pkg::S_IDLE : spm_pkg::S_RD;
            spm_pkg::K_POPMAX: state_nxt = empty ? spm_pkg::S_IDLE : spm_pkg::S_SCAN;
            default:           state_nxt = spm_pkg::S_IDLE;
          endcase
        end
      end
      spm_pkg::S_RD: state_nxt = spm_pkg::S_IDLE;
      spm_pkg::S_SCAN: begin
        if (idx_r == '0) begin
          state_nxt = (scan_best_idx == top_idx) ? spm_pkg::S_IDLE : spm_pkg::S_SHIFT;
        end
      end
      spm_pkg::S_SHIFT: begin
        if (idx_r == top_idx) begin
          state_nxt = spm_pkg::S_IDLE;
        end
      end
      default: state_nxt = spm_pkg::S_IDLE;
    endcase
  end

  // Memory accesses, result and datapath updates
  always_comb begin
    req          = '0;
    res          = '0;
    res.status   = spm_pkg::ST_OK;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    best_idx_nxt = best_idx_r;
    best_val_nxt = best_val_r;
    first_nxt    = first_r;
    kind_nxt     = kind_r;
    unique case (state_r)
      spm_pkg::S_IDLE: begin
        if (accept) begin
          kind_nxt = kind_in;
          unique case (kind_in)
            spm_pkg::K_PUSH: begin
              res.valid = 1'b1;
              if (full) begin
                res.status = spm_pkg::ST_OVER;
              end else begin
                req.we    = 1'b1;
                req.waddr = count_r[spm_pkg::ADDR_W-1:0];
                req.wdata = in_push_value;
                count_nxt = count_r + spm_pkg::CNT_W'(1);
              end
            end
            spm_pkg::K_POP,
            spm_pkg::K_TOP,
            spm_pkg::K_POPMAX: begin
              if (empty) begin
                res.valid  = 1'b1;
                res.status = spm_pkg::ST_UNDER;
              end else begin
                req.re    = 1'b1;
                req.raddr = top_idx;
                idx_nxt   = top_idx;
                first_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      spm_pkg::S_RD: begin
        res.valid = 1'b1;
        res.value = rdata;
        if (kind_r == spm_pkg::K_POP) begin
          count_nxt = count_r - spm_pkg::CNT_W'(1);
        end
      end
      spm_pkg::S_SCAN: begin
        // Keep the topmost largest: replace only on strictly greater
        best_idx_nxt = scan_best_idx;
        best_val_nxt = scan_best_val;
        first_nxt    = 1'b0;
        if (idx_r == '0) begin
          if (scan_best_idx == top_idx) begin
            res.valid = 1'b1;
            res.value = scan_best_val;
            count_nxt = count_r - spm_pkg::CNT_W'(1);
          end else begin
            req.re    = 1'b1;
            req.raddr = scan_best_idx + spm_pkg::ADDR_W'(1);
            idx_nxt   = scan_best_idx + spm_pkg::ADDR_W'(1);
          end
        end else begin
          req.re    = 1'b1;
          req.raddr = idx_r - spm_pkg::ADDR_W'(1);
          idx_nxt   = idx_r - spm_pkg::ADDR_W'(1);
        end
      end
      spm_pkg::S_SHIFT: begin
        // Move the entry just read down one place, read the next one up
        req.we    = 1'b1;
        req.waddr = idx_r - spm_pkg::ADDR_W'(1);
        req.wdata = rdata;
        if (idx_r == top_idx) begin
          res.valid = 1'b1;
          res.value = best_val_r;
          count_nxt = count_r - spm_pkg::CNT_W'(1);
        end else begin
          req.re    = 1'b1;
          req.raddr = idx_r + spm_pkg::ADDR_W'(1);
          idx_nxt   = idx_r + spm_pkg::ADDR_W'(1);
        end
      end
      default: ;
    endcase
    res.count = count_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spm_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers of the current command
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
    first_r    <= first_nxt;
    kind_r     <= kind_nxt;
  end

endmodule

>>> rtl/stack_with_pop_maximum_unit.sv
// Top level of the stack with pop-maximum unit.
//
//  channel  | handshake        | beat
//  ---------+------------------+---------------------------------------------
//  command  | start, busy      | in_kind, in_push_value
//  result   | out_strobe       | out_result_value, out_status, out_is_empty,
//           |                  | out_fill_count
//
// A push finishes in the cycle that accepts it; pop and read top make one store read.
// Pop maximum reads every held entry once from the top down, then moves each
// entry above the maximum down one place, all through the single read port of
// the element store.
// Each result appears in the cycle after the command's last step, for one cycle.
// Reset empties the stack; the store itself is not cleared.
// The receiver cannot stall; busy holds off only new commands.
`include "stack_with_pop_maximum_unit_defines.svh"

module stack_with_pop_maximum_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_kind,
  input  logic [spm_pkg::DATA_WIDTH-1:0] in_push_value,
  output logic                           out_strobe,
  output logic [spm_pkg::DATA_WIDTH-1:0] out_result_value,
  output logic [1:0]                     out_status,
  output logic                           out_is_empty,
  output logic [spm_pkg::CNT_W-1:0]      out_fill_count
);

  spm_pkg::ram_req_t              req;
  spm_pkg::res_t                  res;
  logic [spm_pkg::DATA_WIDTH-1:0] rdata;

  spm_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_kind       (in_kind),
    .in_push_value (in_push_value),
    .rdata         (rdata),
    .busy          (busy),
    .req           (req),
    .res           (res)
  );

  spm_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // Hold the result beat for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_result_value <= res.value;
    out_status       <= res.status;
    out_is_empty     <= (res.count == '0);
    out_fill_count   <= res.count;
  end

  `SPM_ASSERT_NOW(a_count_range, out_strobe, out_fill_count <= spm_pkg::CNT_W'(spm_pkg::DEPTH), "fill count beyond depth")
  `SPM_ASSERT_NOW(a_empty_flag, out_strobe, out_is_empty == (out_fill_count == '0), "empty flag disagrees with count")
  `SPM_ASSERT_NOW(a_overflow_full, out_strobe && (out_status == spm_pkg::ST_OVER), out_fill_count == spm_pkg::CNT_W'(spm_pkg::DEPTH), "overflow while not full")
  `SPM_ASSERT_NEXT(a_push_result, start && !busy && (in_kind == spm_pkg::K_PUSH), out_strobe && !busy, "push gave no result next cycle")

endmodule
